// ===== rtl/core/kbuq_pkg.sv =====
// Shared constants, word types and helpers for the keyed bounded update queue.
`timescale 1ns / 1ps

package kbuq_pkg;

   localparam int unsigned DEPTH    = 64;
   localparam int unsigned ADDR_W   = $clog2(DEPTH);
   localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
   localparam int unsigned CFG_W    = 7;
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned HANDLE_W = 64;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned DROP_W   = 7;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ITEM   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

   typedef struct packed {
      logic                func;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] item;
      logic [DROP_W-1:0]   dropped;
      logic                last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      SCAN_FILTER,
      SCAN_SHIFT,
      SCAN_EXTRACT
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          scan_init;
      logic          scan_en;
      scan_mode_type mode;
      logic          commit;
      logic          append;
      logic          finish_extract;
   } dp_cmd_type;

   typedef struct packed {
      logic is_extract;
      logic full;
      logic scan_done;
   } dp_sts_type;

   // Clamp the programmed capacity into 1..DEPTH.
   function automatic logic [CNT_W-1:0] cap_limit(input logic [CFG_W-1:0] raw);
      logic [CNT_W-1:0] res;
      if (raw == '0) begin
         res = CNT_W'(1);
      end else if (raw > CFG_W'(DEPTH)) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(raw);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/kbuq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module kbuq_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kbuq_datapath.sv =====
// Datapath: entry store, scan pointers, counters and result register.
`timescale 1ns / 1ps

module kbuq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  kbuq_pkg::dp_cmd_type    cmd,
   output kbuq_pkg::dp_sts_type    sts,
   input  kbuq_pkg::req_word_type  req_word,
   input  logic                    csr_wr_en,
   input  logic [kbuq_pkg::CFG_W-1:0] csr_wr_data,
   output logic                    rsp_valid,
   output kbuq_pkg::rsp_word_type  rsp_word
);

   logic [kbuq_pkg::CFG_W-1:0]    cap_ff, cap_in;
   logic [kbuq_pkg::CNT_W-1:0]    held_ff, held_in;
   logic [kbuq_pkg::CNT_W-1:0]    rd_ff, rd_in;
   logic [kbuq_pkg::CNT_W-1:0]    wr_ff, wr_in;
   logic                          pv_ff, pv_in;
   logic                          pend_vld_ff, pend_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kbuq_pkg::DROP_W-1:0]   drop_ff, drop_in;
   logic [kbuq_pkg::HANDLE_W-1:0] pend_item_ff, pend_item_in;
   kbuq_pkg::req_word_type        req_ff, req_in;
   kbuq_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   logic [kbuq_pkg::CNT_W-1:0]    cap_use;
   logic [kbuq_pkg::CNT_W-1:0]    excess;
   logic [kbuq_pkg::KEY_W-1:0]    key_rd;
   logic [kbuq_pkg::HANDLE_W-1:0] handle_rd;
   logic                          hit, issue, proc, keep;
   logic                          mem_we;
   logic [kbuq_pkg::ADDR_W-1:0]   mem_waddr;
   logic [kbuq_pkg::KEY_W-1:0]    mem_wkey;
   logic [kbuq_pkg::HANDLE_W-1:0] mem_whandle;

   assign cap_use = kbuq_pkg::cap_limit(cap_ff);
   assign excess  = held_ff - cap_use + kbuq_pkg::CNT_W'(1);
   assign hit     = (key_rd == req_ff.key);
   assign issue   = cmd.scan_en && (rd_ff < held_ff);
   assign proc    = cmd.scan_en && pv_ff;

   always_comb begin
      case (cmd.mode)
         kbuq_pkg::SCAN_FILTER:  keep = hit;
         kbuq_pkg::SCAN_SHIFT:   keep = 1'b1;
         kbuq_pkg::SCAN_EXTRACT: keep = !hit;
         default:                keep = 1'b0;
      endcase
   end

   // Compacting writes always land below the read pointer.
   assign mem_we      = (proc && keep) || cmd.append;
   assign mem_waddr   = cmd.append ? held_ff[kbuq_pkg::ADDR_W-1:0]
                                   : wr_ff[kbuq_pkg::ADDR_W-1:0];
   assign mem_wkey    = cmd.append ? req_ff.key : key_rd;
   assign mem_whandle = cmd.append ? req_ff.payload : handle_rd;

   kbuq_ram #(.WIDTH(kbuq_pkg::KEY_W), .DEPTH(kbuq_pkg::DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wkey),
      .rd_addr (rd_ff[kbuq_pkg::ADDR_W-1:0]),
      .rd_data (key_rd)
   );

   kbuq_ram #(.WIDTH(kbuq_pkg::HANDLE_W), .DEPTH(kbuq_pkg::DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_whandle),
      .rd_addr (rd_ff[kbuq_pkg::ADDR_W-1:0]),
      .rd_data (handle_rd)
   );

   always_comb begin
      cap_in       = cap_ff;
      held_in      = held_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      pv_in        = pv_ff;
      pend_vld_in  = pend_vld_ff;
      pend_item_in = pend_item_ff;
      drop_in      = drop_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      if (cmd.load) begin
         req_in      = req_word;
         drop_in     = '0;
         pend_vld_in = 1'b0;
      end

      if (cmd.scan_init) begin
         wr_in = '0;
         pv_in = 1'b0;
         if (cmd.mode == kbuq_pkg::SCAN_SHIFT) begin
            // skip the oldest entries so exactly one slot is left free
            rd_in   = excess;
            drop_in = drop_ff + kbuq_pkg::DROP_W'(excess);
         end else begin
            rd_in = '0;
         end
      end

      if (cmd.scan_en) begin
         pv_in = issue;
         if (issue) begin
            rd_in = rd_ff + kbuq_pkg::CNT_W'(1);
         end
         if (proc) begin
            if (keep) begin
               wr_in = wr_ff + kbuq_pkg::CNT_W'(1);
            end else if (cmd.mode == kbuq_pkg::SCAN_FILTER) begin
               drop_in = drop_ff + kbuq_pkg::DROP_W'(1);
            end
            if (cmd.mode == kbuq_pkg::SCAN_EXTRACT && hit) begin
               // hold one match back so the final one can carry last
               pend_item_in = handle_rd;
               pend_vld_in  = 1'b1;
               if (pend_vld_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_word_in.kind    = kbuq_pkg::KIND_ITEM;
                  rsp_word_in.item    = pend_item_ff;
                  rsp_word_in.dropped = '0;
                  rsp_word_in.last    = 1'b0;
               end
            end
         end
      end

      if (cmd.commit) begin
         held_in = wr_ff;
      end

      if (cmd.append) begin
         held_in             = held_ff + kbuq_pkg::CNT_W'(1);
         rsp_valid_in        = 1'b1;
         rsp_word_in.kind    = kbuq_pkg::KIND_INSERT;
         rsp_word_in.item    = '0;
         rsp_word_in.dropped = drop_ff;
         rsp_word_in.last    = 1'b1;
      end

      if (cmd.finish_extract) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.dropped = '0;
         rsp_word_in.last    = 1'b1;
         if (pend_vld_ff) begin
            rsp_word_in.kind = kbuq_pkg::KIND_ITEM;
            rsp_word_in.item = pend_item_ff;
         end else begin
            rsp_word_in.kind = kbuq_pkg::KIND_EMPTY;
            rsp_word_in.item = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= kbuq_pkg::CAP_RESET;
         held_ff      <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pv_ff        <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         held_ff      <= held_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pv_ff        <= pv_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      drop_ff      <= drop_in;
      pend_item_ff <= pend_item_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign sts.is_extract = (req_ff.func == kbuq_pkg::FUNC_EXTRACT);
   assign sts.full       = (held_ff >= cap_use);
   assign sts.scan_done  = !(rd_ff < held_ff) && !pv_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/core/kbuq_ctrl.sv =====
// Controller: sequences the scan passes of insert and extract.
`timescale 1ns / 1ps

module kbuq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output kbuq_pkg::dp_cmd_type cmd,
   input  kbuq_pkg::dp_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FILTER,
      ST_FCHECK,
      ST_SHIFT,
      ST_APPEND,
      ST_EXTRACT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      cmd.mode = kbuq_pkg::SCAN_FILTER;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_extract) begin
               cmd.scan_init = 1'b1;
               cmd.mode      = kbuq_pkg::SCAN_EXTRACT;
               state_in      = ST_EXTRACT;
            end else if (sts.full) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_FILTER;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_FILTER: begin
            if (sts.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_FCHECK;
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         ST_FCHECK: begin
            if (sts.full) begin
               cmd.scan_init = 1'b1;
               cmd.mode      = kbuq_pkg::SCAN_SHIFT;
               state_in      = ST_SHIFT;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_SHIFT: begin
            cmd.mode = kbuq_pkg::SCAN_SHIFT;
            if (sts.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_APPEND;
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            busy_in    = 1'b0;
            state_in   = ST_IDLE;
         end
         ST_EXTRACT: begin
            cmd.mode = kbuq_pkg::SCAN_EXTRACT;
            if (sts.scan_done) begin
               cmd.commit         = 1'b1;
               cmd.finish_extract = 1'b1;
               busy_in            = 1'b0;
               state_in           = ST_IDLE;
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/core/keyed_bounded_update_queue_unit.sv =====
// Top level of the keyed bounded update queue: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Handshake
// request   start, busy, req_word                   in         accept on start && !busy
// response  rsp_valid, rsp_word                     out        one-cycle strobe, no stall
// config    csr_wr_en, csr_wr_data                  in         write on csr_wr_en
//
// Passes: an insert into a store below capacity goes straight to the append
// after accept. A full insert first runs a filter pass over the held entries,
// and when the store is still full a shift pass over the kept entries follows.
// An extract runs a scan pass over the held entries up to its final word; each
// pass reads the entry store through its one read port.
// Reset: synchronous; the store comes up empty with capacity 64, no clearing pass.
// Stalls: the receiver cannot stall; results leave on a strobe, one per cycle.

module keyed_bounded_update_queue_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  kbuq_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   output kbuq_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_wr_en,
   input  logic [kbuq_pkg::CFG_W-1:0] csr_wr_data
);

   kbuq_pkg::dp_cmd_type dp_cmd;
   kbuq_pkg::dp_sts_type dp_sts;

   // Sequence: accept word, decide the passes, scan, then append or finish.
   kbuq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (dp_cmd),
      .sts   (dp_sts)
   );

   // Hold the entries compacted in insertion order; slot 0 is the oldest.
   kbuq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .sts         (dp_sts),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== rtl/core/kbuq_checker.sv =====
// Port-level checks on the update queue, bound to the top level.
`timescale 1ns / 1ps

module kbuq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input kbuq_pkg::rsp_word_type rsp_word
);

   // An accepted word keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after accept");

   // Insert-done and nothing-found words are always final.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind != kbuq_pkg::KIND_ITEM |-> rsp_word.last)
      else $error("single-word result without last");

   // A non-final word means the same request is still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> busy)
      else $error("non-final word while idle");

   // Nothing follows the final word directly.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |=> !rsp_valid)
      else $error("word right after the final word");

   // Extracted items never report drops.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == kbuq_pkg::KIND_ITEM |-> rsp_word.dropped == '0)
      else $error("extracted item with nonzero dropped");

endmodule

bind keyed_bounded_update_queue_unit kbuq_checker u_kbuq_checker (.*);

// ===== dv/keyed_bounded_update_queue_unit_tb.sv =====
// Self-checking testbench for the keyed bounded update queue unit.
`timescale 1ns / 1ps

module keyed_bounded_update_queue_unit_tb;

   // Track the held updates in insertion order and queue the words due back.
   class keyed_store_tracker;
      logic [kbuq_pkg::KEY_W-1:0]    held_key[$];
      logic [kbuq_pkg::HANDLE_W-1:0] held_handle[$];
      kbuq_pkg::rsp_word_type        due_rsp[$];
      logic [kbuq_pkg::CFG_W-1:0]    cap_raw;
      int unsigned                   errors;

      function new();
         cap_raw = kbuq_pkg::CAP_RESET;
         errors  = 0;
      endfunction

      function void set_capacity(logic [kbuq_pkg::CFG_W-1:0] raw);
         cap_raw = raw;
      endfunction

      function int unsigned pending();
         return due_rsp.size();
      endfunction

      function void note_word(kbuq_pkg::req_word_type w);
         kbuq_pkg::rsp_word_type        r;
         int unsigned                   cap;
         int unsigned                   dropped;
         int unsigned                   excess;
         logic [kbuq_pkg::KEY_W-1:0]    kept_key[$];
         logic [kbuq_pkg::HANDLE_W-1:0] kept_handle[$];
         logic [kbuq_pkg::HANDLE_W-1:0] hits[$];
         r = '0;
         if (w.func == kbuq_pkg::FUNC_INSERT) begin
            if (cap_raw == '0) begin
               cap = 1;
            end else if (cap_raw > kbuq_pkg::DEPTH) begin
               cap = kbuq_pkg::DEPTH;
            end else begin
               cap = int'(cap_raw);
            end
            dropped = 0;
            // full store: keep only the entries of the incoming key
            if (held_key.size() >= cap) begin
               foreach (held_key[i]) begin
                  if (held_key[i] == w.key) begin
                     kept_key.insert(kept_key.size(), held_key[i]);
                     kept_handle.insert(kept_handle.size(), held_handle[i]);
                  end else begin
                     dropped++;
                  end
               end
               held_key    = kept_key;
               held_handle = kept_handle;
            end
            // still full: drop the oldest so exactly one slot is free
            if (held_key.size() >= cap) begin
               excess = held_key.size() - (cap - 1);
               repeat (excess) begin
                  held_key.delete(0);
                  held_handle.delete(0);
               end
               dropped += excess;
            end
            if (held_key.size() < kbuq_pkg::DEPTH) begin
               held_key.insert(held_key.size(), w.key);
               held_handle.insert(held_handle.size(), w.payload);
            end
            r.kind    = kbuq_pkg::KIND_INSERT;
            r.dropped = kbuq_pkg::DROP_W'(dropped);
            r.last    = 1'b1;
            due_rsp.insert(due_rsp.size(), r);
         end else begin
            foreach (held_key[i]) begin
               if (held_key[i] == w.key) begin
                  hits.insert(hits.size(), held_handle[i]);
               end else begin
                  kept_key.insert(kept_key.size(), held_key[i]);
                  kept_handle.insert(kept_handle.size(), held_handle[i]);
               end
            end
            held_key    = kept_key;
            held_handle = kept_handle;
            if (hits.size() == 0) begin
               r.kind = kbuq_pkg::KIND_EMPTY;
               r.last = 1'b1;
               due_rsp.insert(due_rsp.size(), r);
            end else begin
               foreach (hits[i]) begin
                  r.kind = kbuq_pkg::KIND_ITEM;
                  r.item = hits[i];
                  r.last = (i == hits.size() - 1);
                  due_rsp.insert(due_rsp.size(), r);
               end
            end
         end
      endfunction

      function void check_word(kbuq_pkg::rsp_word_type got);
         kbuq_pkg::rsp_word_type want;
         if (due_rsp.size() == 0) begin
            $error("response with none expected: kind %0d item %h", got.kind, got.item);
            errors++;
         end else begin
            want = due_rsp[0];
            due_rsp.delete(0);
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, got.kind);
               errors++;
            end
            if (got.item !== want.item) begin
               $error("item: expected %h, got %h", want.item, got.item);
               errors++;
            end
            if (got.dropped !== want.dropped) begin
               $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      endfunction
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       start       = 1'b0;
   logic                       busy;
   kbuq_pkg::req_word_type     req_word    = '0;
   logic                       rsp_valid;
   kbuq_pkg::rsp_word_type     rsp_word;
   logic                       csr_wr_en   = 1'b0;
   logic [kbuq_pkg::CFG_W-1:0] csr_wr_data = '0;

   keyed_store_tracker tracker = new();
   int unsigned        gap_pct = 0;

   localparam logic [kbuq_pkg::KEY_W-1:0] KEY_ZERO = '0;
   localparam logic [kbuq_pkg::KEY_W-1:0] KEY_ONES = '1;
   localparam logic [kbuq_pkg::KEY_W-1:0] KEY_A    = 64'hA5A5_5A5A_0F0F_F0F0;
   localparam logic [kbuq_pkg::KEY_W-1:0] KEY_B    = 64'h5A5A_A5A5_F0F0_0F0F;

   always #5 clock = ~clock;

   keyed_bounded_update_queue_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         tracker.check_word(rsp_word);
      end
   end

   function automatic kbuq_pkg::req_word_type make_word(logic f,
                                                        logic [kbuq_pkg::KEY_W-1:0] k,
                                                        logic [kbuq_pkg::HANDLE_W-1:0] p);
      kbuq_pkg::req_word_type w;
      w.func    = f;
      w.key     = k;
      w.payload = p;
      return w;
   endfunction

   // Hold start high until the word is taken; with chance gap_pct, idle for a random gap first.
   task automatic send_word(input kbuq_pkg::req_word_type w);
      int unsigned gap;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 12);
      end
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      tracker.note_word(w);
   endtask

   // Drop start and wait until every expected word is back and the unit is idle.
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [kbuq_pkg::CFG_W-1:0] raw);
      quiesce();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_capacity(raw);
   endtask

   task automatic run_phase(input logic [kbuq_pkg::CFG_W-1:0] cap,
                            input int unsigned count,
                            input int unsigned pool_n, input int unsigned ext_pct,
                            input int unsigned idle_pct);
      logic [kbuq_pkg::KEY_W-1:0]    pool[$];
      logic [kbuq_pkg::KEY_W-1:0]    k;
      logic [kbuq_pkg::HANDLE_W-1:0] p;
      logic                          f;
      write_capacity(cap);
      gap_pct = idle_pct;
      repeat (pool_n) pool.insert(pool.size(), {$urandom, $urandom});
      // keep the all-zero and all-one keys in play now and then
      if ($urandom_range(1) == 1) pool[0] = KEY_ONES;
      if (pool_n > 1 && $urandom_range(1) == 1) pool[1] = KEY_ZERO;
      repeat (count) begin
         if ($urandom_range(99) < 8) begin
            k = {$urandom, $urandom};
         end else begin
            k = pool[$urandom_range(pool_n - 1)];
         end
         f = ($urandom_range(99) < ext_pct) ? kbuq_pkg::FUNC_EXTRACT : kbuq_pkg::FUNC_INSERT;
         p = {$urandom, $urandom};
         send_word(make_word(f, k, p));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, extreme keys and handles, miss on a non-empty store
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_ZERO, '1));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_ONES, '1));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_ZERO, '0));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_A, '0));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_ONES, '0));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_ZERO, '1));

      // full store: evict other keys, then the oldest of the same key
      write_capacity(kbuq_pkg::CFG_W'(4));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h1));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_B, 64'h2));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h3));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_B, 64'h4));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h5));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h6));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h7));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_A, '0));

      // capacity lowered below the held count
      write_capacity(kbuq_pkg::CFG_W'(8));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h11));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_B, 64'h12));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h13));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h14));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_B, 64'h15));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h16));
      write_capacity(kbuq_pkg::CFG_W'(2));
      send_word(make_word(kbuq_pkg::FUNC_INSERT, KEY_A, 64'h17));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_B, '0));
      send_word(make_word(kbuq_pkg::FUNC_EXTRACT, KEY_A, '0));

      // cap, words, pool size, extract %, sender idle %
      run_phase(kbuq_pkg::CFG_W'(64), 100, 48, 10, 0);
      run_phase(kbuq_pkg::CFG_W'(1), 30, 3, 30, 51);
      run_phase(kbuq_pkg::CFG_W'(0), 20, 2, 30, 14);
      run_phase(kbuq_pkg::CFG_W'(127), 60, 6, 25, 51);
      run_phase(kbuq_pkg::CFG_W'(5), 50, 3, 25, 0);
      run_phase(kbuq_pkg::CFG_W'(2), 40, 2, 30, 14);
      run_phase(kbuq_pkg::CFG_W'(33), 50, 10, 20, 51);

      quiesce();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
